// ===== rtl/core/hcbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, codes and helpers for the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_DIGITS   = 4'd1,
    PH_EXT      = 4'd2,
    PH_DATA     = 4'd3,
    PH_SKIP1    = 4'd4,
    PH_SKIP2    = 4'd5,
    PH_TRAILER  = 4'd6,
    PH_DONE     = 4'd7,
    PH_ERR_FORM = 4'd8,
    PH_ERR_OVER = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_DONE = 3'd1,
    ST_FORM = 3'd2,
    ST_OVER = 3'd3,
    ST_PAST = 3'd4
  } status_t;

  typedef struct packed {
    phase_t               phase;
    logic [SIZE_BITS-1:0] chunk_remaining;
    logic                 cr_seen;
    logic                 trailer_empty;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_t    decode_status;
  } result_t;

  localparam dec_state_t STATE_RESET = '{
    phase:           PH_LEAD,
    chunk_remaining: '0,
    cr_seen:         1'b0,
    trailer_empty:   1'b1
  };

  // returns {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hcbd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd channel interfaces
// valid/ready channels for raw body bytes and decoded results
// ----------------------------------------------------------------------------
interface hcbd_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_message;

  modport source (output valid, output data_byte, output start_message, input ready);
  modport sink   (input valid, input data_byte, input start_message, output ready);
endinterface

interface hcbd_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [2:0] decode_status;

  modport source (output valid, output payload_byte, output payload_valid,
                  output decode_status, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input decode_status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hcbd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_step
// next decoder state and result for one body byte
// ----------------------------------------------------------------------------
module hcbd_step
  import hcbd_pkg::*;
(
  input  dec_state_t state,
  input  logic [7:0] data_byte,
  input  logic       start_message,
  output dec_state_t state_next,
  output result_t    result
);

  dec_state_t cur;
  logic [4:0] hx;
  logic       is_hex;
  logic       line_end;

  assign cur      = start_message ? STATE_RESET : state;
  assign hx       = hex_decode(data_byte);
  assign is_hex   = hx[4];
  assign line_end = (data_byte == CHR_LF) && cur.cr_seen;

  always_comb begin
    state_next           = cur;
    result.payload_byte  = 8'h00;
    result.payload_valid = 1'b0;
    result.decode_status = ST_RUN;
    case (cur.phase)
      PH_LEAD: begin
        if (data_byte != CHR_SPACE && data_byte != CHR_TAB) begin
          if (!is_hex) begin
            state_next.phase     = PH_ERR_FORM;
            result.decode_status = ST_FORM;
          end else begin
            state_next.chunk_remaining = {{(SIZE_BITS-4){1'b0}}, hx[3:0]};
            state_next.phase           = PH_DIGITS;
          end
        end
      end
      PH_DIGITS: begin
        if (is_hex) begin
          if (cur.chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
            state_next.phase     = PH_ERR_OVER;
            result.decode_status = ST_OVER;
          end else begin
            state_next.chunk_remaining = {cur.chunk_remaining[SIZE_BITS-5:0], hx[3:0]};
          end
        end else begin
          // first non-digit opens the ignored tail of the size line
          state_next.phase   = PH_EXT;
          state_next.cr_seen = (data_byte == CHR_CR);
        end
      end
      PH_EXT: begin
        if (line_end) begin
          state_next.cr_seen = 1'b0;
          if (cur.chunk_remaining == '0) begin
            state_next.trailer_empty = 1'b1;
            state_next.phase         = PH_TRAILER;
          end else begin
            state_next.phase = PH_DATA;
          end
        end else begin
          state_next.cr_seen = (data_byte == CHR_CR);
        end
      end
      PH_DATA: begin
        result.payload_valid       = 1'b1;
        result.payload_byte        = data_byte;
        state_next.chunk_remaining = cur.chunk_remaining - {{(SIZE_BITS-1){1'b0}}, 1'b1};
        if (cur.chunk_remaining == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
          state_next.phase = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        state_next.phase = PH_SKIP2;
      end
      PH_SKIP2: begin
        state_next.phase           = PH_LEAD;
        state_next.chunk_remaining = '0;
        state_next.cr_seen         = 1'b0;
      end
      PH_TRAILER: begin
        if (line_end) begin
          state_next.cr_seen = 1'b0;
          if (cur.trailer_empty) begin
            state_next.phase     = PH_DONE;
            result.decode_status = ST_DONE;
          end else begin
            state_next.trailer_empty = 1'b1;
          end
        end else if (data_byte == CHR_CR) begin
          if (cur.cr_seen) begin
            state_next.trailer_empty = 1'b0;
          end
          state_next.cr_seen = 1'b1;
        end else begin
          state_next.trailer_empty = 1'b0;
          state_next.cr_seen       = 1'b0;
        end
      end
      PH_DONE: begin
        result.decode_status = ST_PAST;
      end
      PH_ERR_OVER: begin
        result.decode_status = ST_OVER;
      end
      default: begin
        state_next.phase     = PH_ERR_FORM;
        result.decode_status = ST_FORM;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/hcbd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_out_stage
// result register driving the payload channel
// ----------------------------------------------------------------------------
module hcbd_out_stage
  import hcbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    can_load,
  hcbd_payload_if.source payload
);

  logic    held;
  result_t data;

  assign can_load = !held || payload.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (payload.ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign payload.valid         = held;
  assign payload.payload_byte  = data.payload_byte;
  assign payload.payload_valid = data.payload_valid;
  assign payload.decode_status = data.decode_status;

endmodule
`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// http/1.1 chunked transfer decoder, one body byte per beat
// ----------------------------------------------------------------------------
// Each beat on the body channel carries one raw byte of a chunked message
// body and yields exactly one result beat on the payload channel: the byte
// itself with payload_valid set when it is chunk data, otherwise a status
// beat (0 running, 1 complete at the blank line ending the trailers,
// 2 malformed size line, 3 chunk size wider than 32 bits, 4 byte after
// completion). Errors repeat on every later beat until a beat arrives with
// start_message set, which clears the decoder before that byte is parsed.
// Throughput is one beat per clock and the result is registered: the parse of
// a byte is a single combinational step from the decoder state register and
// the incoming beat into the result register, and the input is stalled only
// while that result register holds a beat the sink has not taken.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hcbd_body_if.sink      body,
  hcbd_payload_if.source payload
);

  // decoder state: phase, remaining chunk count, line-end tracking
  dec_state_t state;
  dec_state_t state_next;
  result_t    result;
  logic       can_load;
  logic       accept;

  // a new byte is taken whenever the result register is free or draining
  assign body.ready = can_load;
  assign accept     = body.valid && can_load;

  hcbd_step u_step (
    .state         (state),
    .data_byte     (body.data_byte),
    .start_message (body.start_message),
    .state_next    (state_next),
    .result        (result)
  );

  // state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  hcbd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .payload  (payload)
  );

endmodule
`default_nettype wire
